// ===== rtl/ssd_pkg.sv =====
package ssd_pkg;

  localparam int POS_W  = 3;
  localparam int CODE_W = 8;
  localparam int FONT_SIZE = 21;
  localparam logic [7:0] DOT_BIT = 8'h02;

  typedef enum logic [1:0] {
    EV_ACCEPT = 2'd0,
    EV_REJECT = 2'd1,
    EV_BIT    = 2'd2,
    EV_STROBE = 2'd3
  } event_kind_t;

  typedef enum logic [0:0] {
    OP_WRITE   = 1'b0,
    OP_REFRESH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOAD   = 2'd1,
    S_SHIFT  = 2'd2,
    S_STROBE = 2'd3
  } seq_state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [POS_W-1:0]  addr;
    logic [CODE_W-1:0] code;
    logic              dot;
  } mem_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              dot;
  } mem_data_t;

  typedef struct packed {
    event_kind_t kind;
    logic        serial_bit;
    logic        last;
  } result_t;

  function automatic logic [7:0] glyph(input logic [CODE_W-1:0] code, input logic dot);
    logic [7:0] v;
    case (code)
      8'd0:    v = 8'h7D;
      8'd1:    v = 8'h0C;
      8'd2:    v = 8'hB5;
      8'd3:    v = 8'h9D;
      8'd4:    v = 8'hCC;
      8'd5:    v = 8'hD9;
      8'd6:    v = 8'hF9;
      8'd7:    v = 8'h0D;
      8'd8:    v = 8'hFD;
      8'd9:    v = 8'hDD;
      8'd10:   v = 8'h02;
      8'd11:   v = 8'h00;
      8'd12:   v = 8'hED;
      8'd13:   v = 8'hF8;
      8'd14:   v = 8'h71;
      8'd15:   v = 8'hBC;
      8'd16:   v = 8'hF1;
      8'd17:   v = 8'hE1;
      8'd18:   v = 8'hA0;
      8'd19:   v = 8'h80;
      8'd20:   v = 8'hC5;
      default: v = 8'h00; // beyond the font: blank
    endcase
    if (dot) v = v | DOT_BIT;
    return v;
  endfunction

endpackage

// ===== rtl/ssd_mem.sv =====
module ssd_mem import ssd_pkg::*; #(
  parameter int DIGITS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mem_req_t  req,
  output mem_data_t rdata
);

  localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  mem_data_t         mem [DIGITS];
  logic [DIGITS-1:0] valid_r;
  mem_data_t         rdata_r;
  logic [AW-1:0]     idx;

  assign idx = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[idx] <= '{code: req.code, dot: req.dot};
    end
  end

  // entries never written read as the cleared value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= valid_r[idx] ? mem[idx] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ssd_seq.sv =====
module ssd_seq import ssd_pkg::*; #(
  parameter int DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [POS_W-1:0]  position,
  input  logic [CODE_W-1:0] symbol_code,
  input  logic              dot_on,
  output mem_req_t          mem_req,
  input  mem_data_t         mem_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  seq_state_t    state_r, state_nxt;
  logic [AW-1:0] digit_r, digit_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [7:0]    glyph_r, glyph_nxt;
  logic          in_fire;
  logic          pos_ok;

  assign pos_ok  = position < POS_W'(DIGITS);
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      digit_r <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      digit_r <= digit_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyph_r <= glyph_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    digit_nxt = digit_r;
    bit_nxt   = bit_r;
    glyph_nxt = glyph_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = '{kind: EV_ACCEPT, serial_bit: 1'b0, last: 1'b0};
    mem_req   = '{we: 1'b0, re: 1'b0, addr: position, code: symbol_code, dot: dot_on};

    unique case (state_r)
      S_IDLE: begin
        in_ready = res_ready;
        if (in_valid && opcode == OP_WRITE) begin
          res_valid = 1'b1;
          res.kind  = pos_ok ? EV_ACCEPT : EV_REJECT;
          res.last  = 1'b1;
        end
        if (in_fire) begin
          if (opcode == OP_WRITE) begin
            mem_req.we = pos_ok;
          end else begin
            mem_req.re   = 1'b1;
            mem_req.addr = POS_W'(DIGITS - 1);
            digit_nxt    = AW'(DIGITS - 1);
            state_nxt    = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        // take this digit, prefetch the next one while it shifts
        glyph_nxt = glyph(mem_rdata.code, mem_rdata.dot);
        bit_nxt   = 3'd7;
        if (digit_r != '0) begin
          mem_req.re   = 1'b1;
          mem_req.addr = POS_W'(digit_r - AW'(1));
        end
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        res_valid      = 1'b1;
        res.kind       = EV_BIT;
        res.serial_bit = ~glyph_r[bit_r];
        if (res_ready) begin
          if (bit_r != 3'd0) begin
            bit_nxt = bit_r - 3'd1;
          end else if (digit_r == '0) begin
            state_nxt = S_STROBE;
          end else begin
            glyph_nxt = glyph(mem_rdata.code, mem_rdata.dot);
            bit_nxt   = 3'd7;
            digit_nxt = digit_r - AW'(1);
            if (digit_r != AW'(1)) begin
              mem_req.re   = 1'b1;
              mem_req.addr = POS_W'(digit_r - AW'(2));
            end
          end
        end
      end
      S_STROBE: begin
        res_valid = 1'b1;
        res.kind  = EV_STROBE;
        res.last  = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/seven_segment_shift_driver.sv =====
// Seven-segment shift-register display driver.
// Input channel (in_valid/in_ready): opcode 0 writes symbol_code and dot_on
// to digit position; opcode 1 refreshes the whole display.
// Result channel (out_valid/out_ready): a write gives one transfer, accept
// or reject (position at or beyond DIGITS), with out_last set. A refresh
// gives 8*DIGITS bit transfers, highest digit first, MSB first, each bit
// inverted, then one latch strobe with out_last set.
// Timing: a write's result is registered and shows in the cycle after
// its transfer. A refresh runs from its transfer through a read of the
// first digit from the digit memory, then the bits of each digit, then
// the strobe, after which the next item can be accepted. The next digit is
// fetched from memory while the current one shifts, so the memory read
// port adds no gaps between digits.
// Reset clears the digit store to code 0 with dots off (valid bit per
// entry) and empties the output register; no clearing pass is needed.
// A stall on out_ready holds the sequencer on the current bit; the output
// register keeps the pending transfer, and in_ready drops while a refresh
// is in progress.
module seven_segment_shift_driver import ssd_pkg::*; #(
  parameter int DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [POS_W-1:0]  in_position,
  input  logic [CODE_W-1:0] in_symbol_code,
  input  logic              in_dot_on,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_event_kind,
  output logic              out_serial_bit,
  output logic              out_last
);

  mem_req_t  mem_req;
  mem_data_t mem_rdata;
  logic      res_valid, res_ready;
  result_t   res;
  logic      out_valid_r;
  result_t   out_res_r;

  ssd_mem #(.DIGITS(DIGITS)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  ssd_seq #(.DIGITS(DIGITS)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (in_opcode),
    .position    (in_position),
    .symbol_code (in_symbol_code),
    .dot_on      (in_dot_on),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_res_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_res_r.kind;
  assign out_serial_bit = out_res_r.serial_bit;
  assign out_last       = out_res_r.last;

  a_mem_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("digit memory written and read in the same cycle");

  a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_WRITE && in_position >= POS_W'(DIGITS))
      |-> !mem_req.we)
    else $error("rejected write reached the digit memory");

  a_bit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == EV_BIT) |-> !out_last)
    else $error("bit transfer marked last");

  a_strobe_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == EV_STROBE) |-> (out_last && !out_serial_bit))
    else $error("strobe transfer malformed");

endmodule

// ===== test/tb_seven_segment_shift_driver.sv =====
`timescale 1ns / 1ps

module tb_seven_segment_shift_driver;
  import ssd_pkg::*;

  localparam int DIGITS = 4;
  localparam int RANDOM_CMDS = 250;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_LEN = 40;
  localparam logic [7:0] SEG_FONT [FONT_SIZE] = '{
    8'h7D, 8'h0C, 8'hB5, 8'h9D, 8'hCC, 8'hD9, 8'hF9, 8'h0D, 8'hFD, 8'hDD,
    8'h02, 8'h00, 8'hED, 8'hF8, 8'h71, 8'hBC, 8'hF1, 8'hE1, 8'hA0,
    8'h80, 8'hC5
  };

  typedef struct packed {
    opcode_t           op;
    logic [POS_W-1:0]  pos;
    logic [CODE_W-1:0] code;
    logic              dot;
  } display_cmd_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_opcode = 1'b0;
  logic [POS_W-1:0]  in_position = '0;
  logic [CODE_W-1:0] in_symbol_code = '0;
  logic              in_dot_on = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_event_kind;
  logic              out_serial_bit;
  logic              out_last;

  display_cmd_t      pending_cmds[$];
  result_t           expected_events[$];
  logic [CODE_W-1:0] shadow_codes [DIGITS];
  logic              shadow_dots [DIGITS];
  int                cmds_sent = 0;
  int                cmds_accepted = 0;
  int                err_count = 0;

  seven_segment_shift_driver #(.DIGITS(DIGITS)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_position    (in_position),
    .in_symbol_code (in_symbol_code),
    .in_dot_on      (in_dot_on),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_serial_bit (out_serial_bit),
    .out_last       (out_last)
  );

  always #2 clk = ~clk;

  task automatic queue_cmd(input opcode_t op, input int pos, input int code, input bit dot);
    display_cmd_t cmd;
    cmd.op = op;
    cmd.pos = pos[POS_W-1:0];
    cmd.code = code[CODE_W-1:0];
    cmd.dot = dot;
    pending_cmds.push_back(cmd);
  endtask

  // updates the shadow display and queues the transfers the command causes
  task automatic predict_display_events(input display_cmd_t cmd);
    logic [7:0] segs;
    result_t    ev;
    if (cmd.op == OP_WRITE) begin
      ev.serial_bit = 1'b0;
      ev.last = 1'b1;
      if (cmd.pos < DIGITS) begin
        shadow_codes[cmd.pos] = cmd.code;
        shadow_dots[cmd.pos] = cmd.dot;
        ev.kind = EV_ACCEPT;
      end else begin
        ev.kind = EV_REJECT;
      end
      expected_events.push_back(ev);
    end else begin
      for (int d = DIGITS - 1; d >= 0; d--) begin
        segs = (shadow_codes[d] < FONT_SIZE) ? SEG_FONT[shadow_codes[d]] : 8'h00;
        if (shadow_dots[d]) segs = segs | DOT_BIT;
        for (int b = 7; b >= 0; b--) begin
          ev.kind = EV_BIT;
          ev.serial_bit = ~segs[b];
          ev.last = 1'b0;
          expected_events.push_back(ev);
        end
      end
      ev.kind = EV_STROBE;
      ev.serial_bit = 1'b0;
      ev.last = 1'b1;
      expected_events.push_back(ev);
    end
  endtask

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  initial begin
    for (int i = 0; i < DIGITS; i++) begin
      shadow_codes[i] = '0;
      shadow_dots[i] = 1'b0;
    end
  end

  // predictor and checker
  always @(posedge clk) begin : check
    result_t ev;
    if (rst_n && in_valid && in_ready) begin
      predict_display_events({opcode_t'(in_opcode), in_position, in_symbol_code, in_dot_on});
      cmds_accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_error($sformatf("unexpected transfer kind=%0d bit=%0b last=%0b",
                               out_event_kind, out_serial_bit, out_last));
      end else begin
        ev = expected_events.pop_front();
        if (out_event_kind != ev.kind || out_serial_bit != ev.serial_bit ||
            out_last != ev.last)
          report_error($sformatf("exp kind=%0d bit=%0b last=%0b, got kind=%0d bit=%0b last=%0b",
                                 ev.kind, ev.serial_bit, ev.last,
                                 out_event_kind, out_serial_bit, out_last));
      end
    end
  end

  // driver: phases cycle none / sender idle / receiver stall / both
  always @(negedge clk) begin : drive
    display_cmd_t cmd;
    int           idle_pct;
    int           stall_pct;
    case ((cmds_sent / PHASE_LEN) % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 46; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 46; end
      default: begin idle_pct = 36; stall_pct = 36; end
    endcase
    if (rst_n) begin
      if (!in_valid || cmds_accepted == cmds_sent) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_opcode <= cmd.op;
          in_position <= cmd.pos;
          in_symbol_code <= cmd.code;
          in_dot_on <= cmd.dot;
          cmds_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    int roll;
    // directed: refresh of the reset display, font edges, rejects, blank codes
    queue_cmd(OP_REFRESH, 0, 0, 0);
    queue_cmd(OP_WRITE, 0, 0, 1);
    queue_cmd(OP_WRITE, 1, 20, 0);
    queue_cmd(OP_WRITE, 2, 21, 1);
    queue_cmd(OP_WRITE, 3, 255, 0);
    queue_cmd(OP_WRITE, 4, 5, 1);
    queue_cmd(OP_WRITE, 7, 255, 1);
    queue_cmd(OP_REFRESH, 7, 255, 1);
    queue_cmd(OP_WRITE, 3, 10, 0);
    queue_cmd(OP_WRITE, 2, 11, 1);
    queue_cmd(OP_WRITE, 1, 8, 1);
    queue_cmd(OP_WRITE, 0, 19, 0);
    queue_cmd(OP_REFRESH, 0, 0, 0);
    queue_cmd(OP_REFRESH, 5, 170, 1);
    queue_cmd(OP_WRITE, 3, 255, 1);
    queue_cmd(OP_WRITE, 5, 0, 0);
    queue_cmd(OP_WRITE, 0, 255, 1);
    queue_cmd(OP_REFRESH, 3, 85, 0);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      roll = $urandom_range(99);
      if (roll < 30)
        queue_cmd(OP_REFRESH, $urandom_range(7), $urandom_range(255), $urandom_range(1));
      else
        queue_cmd(OP_WRITE,
                  (roll < 85) ? $urandom_range(DIGITS - 1) : $urandom_range(7, DIGITS),
                  ($urandom_range(9) < 8) ? $urandom_range(FONT_SIZE - 1)
                                          : $urandom_range(255, FONT_SIZE),
                  $urandom_range(1));
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_seven_segment_shift_driver: clean");
    end else begin
      $display("tb_seven_segment_shift_driver: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb_seven_segment_shift_driver: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ssd_pkg.sv
rtl/ssd_mem.sv
rtl/ssd_seq.sv
rtl/seven_segment_shift_driver.sv
test/tb_seven_segment_shift_driver.sv
